// File: rtl/nperm_pkg.sv
// nperm_pkg: shared widths, codes and command type of the permutation generator
// no dependencies; compile first

package nperm_pkg;

    // store geometry
    localparam int MAX_DIGITS = 10;
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 3;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ascii digit range
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    // input action codes
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STEP  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_DIGIT = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_TOO_MANY  = 3'd3,
        ST_EXHAUSTED = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    // classified command kinds
    typedef enum logic [1:0] {
        K_CLEAR = 2'd0,
        K_LOAD  = 2'd1,
        K_STEP  = 2'd2
    } t_kind;

    // one queued command
    typedef struct packed {
        t_kind               kind;
        logic [DIGIT_W-1:0]  digit;
        logic                not_digit;
    } t_cmd;

endpackage

// File: rtl/nperm_if.sv
// nperm_in_if / nperm_out_if: valid/ready channels of the permutation generator
// depends on nperm_pkg

interface nperm_in_if import nperm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_in;

    modport source (output valid, output action, output char_in, input ready);
    modport sink   (input valid, input action, input char_in, output ready);
endinterface

interface nperm_out_if import nperm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DIGIT_W-1:0]  digit;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output digit, output status, output last, input ready);
    modport sink   (input valid, input digit, input status, input last, output ready);
endinterface

// File: rtl/next_permutation_generator.sv
// next_permutation_generator: top level, front classifier, command queue and back sequencer
// depends on nperm_pkg, nperm_if, nperm_front, nperm_fifo, nperm_back

// Holds up to ten distinct decimal digits and steps them through lexicographic
// permutations. A clear beat empties the store and gives no result; a load beat
// gives one result (ok, not a digit, duplicate or too many); a step beat gives one
// result per stored digit with last on the final one, or a single exhausted or
// empty result. Beats pass a classifying register and a two-entry command queue
// before the back sequencer. In the back, clear, load and a step on an empty store
// are handled in the idle state; a step on n digits runs an ascent scan, a pivot
// fetch, a larger-digit scan, a swap, a read and a write state per reversed pair
// and an emit beat per digit, since the store has a single read port. Output
// backpressure stalls the back, and the front too once the queue is full.

module next_permutation_generator import nperm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nperm_in_if.sink      i_in,
    nperm_out_if.source   o_out
);

    logic push_valid;
    t_cmd push_cmd;
    logic push_ready;
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    nperm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    nperm_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (cmd_valid),
        .o_pop_cmd    (cmd),
        .i_pop        (cmd_pop)
    );

    nperm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    // the back never takes a command from an empty queue
    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    // a command refused by the queue stays put in the front register
    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_valid && !push_ready |=> push_valid && $stable(push_cmd))
        else $error("front command lost while queue full");

    // every non-ok result is a single-beat result
    a_reject_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status != ST_OK) |-> o_out.last)
        else $error("non-ok result without last");
`endif

endmodule

// File: rtl/nperm_front.sv
// nperm_front: takes input beats, classifies them into commands, holds one in a register
// depends on nperm_pkg and nperm_in_if

module nperm_front import nperm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nperm_in_if.sink      i_in,
    output logic          o_push_valid,
    output t_cmd          o_push_cmd,
    input  logic          i_push_ready
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;
    logic is_digit;

    // register frees up when empty or when the queue takes it
    assign i_in.ready = !r_valid || i_push_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign is_digit   = (i_in.char_in >= CHAR_ZERO) && (i_in.char_in <= CHAR_NINE);

    // classify the beat; unused action code is dropped here
    always_comb begin
        n_valid = r_valid && !i_push_ready;
        n_cmd   = r_cmd;
        if (accept) begin
            n_cmd.digit     = is_digit ? DIGIT_W'(i_in.char_in - CHAR_ZERO) : '0;
            n_cmd.not_digit = !is_digit;
            case (i_in.action)
                ACT_CLEAR: begin
                    n_cmd.kind = K_CLEAR;
                    n_valid    = 1'b1;
                end
                ACT_LOAD: begin
                    n_cmd.kind = K_LOAD;
                    n_valid    = 1'b1;
                end
                ACT_STEP: begin
                    n_cmd.kind = K_STEP;
                    n_valid    = 1'b1;
                end
                default: begin
                    n_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

endmodule

// File: rtl/nperm_fifo.sv
// nperm_fifo: short command queue between the front and the back
// depends on nperm_pkg

module nperm_fifo import nperm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    input  t_cmd  i_push_cmd,
    output logic  o_push_ready,
    output logic  o_pop_valid,
    output t_cmd  o_pop_cmd,
    input  logic  i_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_fill;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_fill;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_fill != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    // pointer wrap and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// File: rtl/nperm_back.sv
// nperm_back: digit store and sequencer for load, clear and next-permutation steps
// depends on nperm_pkg and nperm_out_if

module nperm_back import nperm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  t_cmd          i_cmd,
    output logic          o_cmd_pop,
    nperm_out_if.source   o_out
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FIND   = 8'b0000_0010,
        S_PIVOT  = 8'b0000_0100,
        S_SEEK   = 8'b0000_1000,
        S_SWAP   = 8'b0001_0000,
        S_REV_RD = 8'b0010_0000,
        S_REV_WR = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [DIGIT_W-1:0]  r_store [MAX_DIGITS];
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic [IDX_W-1:0]    r_lo;
    logic [IDX_W-1:0]    n_lo;
    logic [IDX_W-1:0]    r_hi;
    logic [IDX_W-1:0]    n_hi;
    logic [DIGIT_W-1:0]  r_hold;
    logic [DIGIT_W-1:0]  n_hold;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [DIGIT_W-1:0]  r_digit;
    logic [DIGIT_W-1:0]  n_digit;
    t_status             r_status;
    t_status             n_status;
    logic                r_last;
    logic                n_last;

    logic                out_free;
    logic [IDX_W-1:0]    rd_addr;
    logic [DIGIT_W-1:0]  rd_data;
    logic                we0;
    logic [IDX_W-1:0]    wa0;
    logic [DIGIT_W-1:0]  wd0;
    logic                we1;
    logic [IDX_W-1:0]    wa1;
    logic [DIGIT_W-1:0]  wd1;
    logic [MAX_DIGITS-1:0] asc;
    logic [MAX_DIGITS-1:0] gt;
    logic [MAX_DIGITS-1:0] dup;
    logic [IDX_W-1:0]    top_idx;

    assign out_free = !r_out_valid || o_out.ready;
    assign rd_data  = r_store[rd_addr];
    assign top_idx  = IDX_W'(r_cnt - CNT_W'(1));

    // per-entry compares: ascent into entry k, larger than held pivot, equal to load digit
    always_comb begin
        asc = '0;
        gt  = '0;
        dup = '0;
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (k > 0) begin
                asc[k] = r_store[k-1] < r_store[k];
            end
            gt[k]  = r_store[k] > r_hold;
            dup[k] = (CNT_W'(k) < r_cnt) && (r_store[k] == i_cmd.digit);
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_hold      = r_hold;
        n_out_valid = r_out_valid && !o_out.ready;
        n_digit     = r_digit;
        n_status    = r_status;
        n_last      = r_last;
        o_cmd_pop   = 1'b0;
        rd_addr     = r_lo;
        we0         = 1'b0;
        wa0         = r_lo;
        wd0         = rd_data;
        we1         = 1'b0;
        wa1         = r_hi;
        wd1         = r_hold;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        K_CLEAR: begin
                            o_cmd_pop = 1'b1;
                            n_cnt     = '0;
                        end
                        K_LOAD: begin
                            if (out_free) begin
                                o_cmd_pop   = 1'b1;
                                n_out_valid = 1'b1;
                                n_digit     = i_cmd.digit;
                                n_last      = 1'b1;
                                if (i_cmd.not_digit) begin
                                    n_status = ST_NOT_DIGIT;
                                end else if (r_cnt >= CNT_W'(MAX_DIGITS)) begin
                                    n_status = ST_TOO_MANY;
                                end else if (dup != '0) begin
                                    n_status = ST_DUPLICATE;
                                end else begin
                                    n_status = ST_OK;
                                    we0      = 1'b1;
                                    wa0      = IDX_W'(r_cnt);
                                    wd0      = i_cmd.digit;
                                    n_cnt    = r_cnt + 1'b1;
                                end
                            end
                        end
                        K_STEP: begin
                            if (r_cnt == '0) begin
                                if (out_free) begin
                                    o_cmd_pop   = 1'b1;
                                    n_out_valid = 1'b1;
                                    n_digit     = '0;
                                    n_status    = ST_EMPTY;
                                    n_last      = 1'b1;
                                end
                            end else begin
                                o_cmd_pop = 1'b1;
                                n_hi      = top_idx;
                                n_state   = S_FIND;
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            // walk left to the rightmost ascent
            S_FIND: begin
                if (r_hi == '0) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_digit     = '0;
                        n_status    = ST_EXHAUSTED;
                        n_last      = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (asc[r_hi]) begin
                    n_lo    = r_hi - 1'b1;
                    n_state = S_PIVOT;
                end else begin
                    n_hi = r_hi - 1'b1;
                end
            end
            // latch the pivot digit
            S_PIVOT: begin
                rd_addr = r_lo;
                n_hold  = rd_data;
                n_hi    = top_idx;
                n_state = S_SEEK;
            end
            // rightmost digit above the pivot
            S_SEEK: begin
                if (gt[r_hi]) begin
                    n_state = S_SWAP;
                end else begin
                    n_hi = r_hi - 1'b1;
                end
            end
            S_SWAP: begin
                rd_addr = r_hi;
                we0     = 1'b1;
                wa0     = r_lo;
                wd0     = rd_data;
                we1     = 1'b1;
                wa1     = r_hi;
                wd1     = r_hold;
                n_lo    = r_lo + 1'b1;
                n_hi    = top_idx;
                n_state = S_REV_RD;
            end
            // reverse the tail, one pair per read state and write state
            S_REV_RD: begin
                if (r_lo < r_hi) begin
                    rd_addr = r_lo;
                    n_hold  = rd_data;
                    n_state = S_REV_WR;
                end else begin
                    n_lo    = '0;
                    n_state = S_EMIT;
                end
            end
            S_REV_WR: begin
                rd_addr = r_hi;
                we0     = 1'b1;
                wa0     = r_lo;
                wd0     = rd_data;
                we1     = 1'b1;
                wa1     = r_hi;
                wd1     = r_hold;
                n_lo    = r_lo + 1'b1;
                n_hi    = r_hi - 1'b1;
                n_state = S_REV_RD;
            end
            // one digit beat per cycle while the output is free, most significant first
            S_EMIT: begin
                if (out_free) begin
                    rd_addr     = r_lo;
                    n_out_valid = 1'b1;
                    n_digit     = rd_data;
                    n_status    = ST_OK;
                    n_last      = (r_lo == top_idx);
                    n_lo        = r_lo + 1'b1;
                    if (r_lo == top_idx) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_hold   <= n_hold;
        r_digit  <= n_digit;
        r_status <= n_status;
        r_last   <= n_last;
    end

    // digit store writes
    always_ff @(posedge i_clk) begin
        if (we0) begin
            r_store[wa0] <= wd0;
        end
        if (we1) begin
            r_store[wa1] <= wd1;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.digit  = r_digit;
    assign o_out.status = r_status;
    assign o_out.last   = r_last;

endmodule
